>>> rtl/lcg_bounded_random_draw_unit_assert.svh
// Assertion macros used by the checker of this block.
// Both sample on clk and are switched off while arst_n is low.
`ifndef LCG_BOUNDED_RANDOM_DRAW_UNIT_ASSERT_SVH
`define LCG_BOUNDED_RANDOM_DRAW_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LBRD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbrd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LBRD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbrd assertion failed");

`endif

>>> rtl/lbrd_pkg.sv
`timescale 1ns / 1ps
package lbrd_pkg;

	localparam int unsigned ACT_W  = 3;
	localparam int unsigned WORD_W = 32;

	typedef logic [ACT_W-1:0]         action_t;
	typedef logic [WORD_W-1:0]        word_t;
	typedef logic signed [WORD_W-1:0] sword_t;

	// request action codes
	localparam action_t ACT_LOAD    = 3'd0;
	localparam action_t ACT_RAW     = 3'd1;
	localparam action_t ACT_ABS     = 3'd2;
	localparam action_t ACT_BOUNDED = 3'd3;
	localparam action_t ACT_DISCARD = 3'd4;
	localparam action_t ACT_COIN    = 3'd5;

	localparam word_t LCG_MULT         = 32'h015A_4E35;
	localparam word_t LCG_INC          = 32'h0000_0001;
	localparam word_t HIGH_BOUND_LIMIT = 32'h0000_7FFF;
	localparam word_t INT_MIN_PAT      = 32'h8000_0000;
	localparam int unsigned HIGH_SHIFT = 16;

endpackage

>>> rtl/lbrd_req_if.sv
`timescale 1ns / 1ps
interface lbrd_req_if;
	import lbrd_pkg::*;

	logic    valid;
	logic    ready;
	action_t action;
	word_t   operand;

	modport source (output valid, action, operand, input ready);
	modport sink (input valid, action, operand, output ready);
endinterface

>>> rtl/lbrd_rsp_if.sv
`timescale 1ns / 1ps
interface lbrd_rsp_if;
	import lbrd_pkg::*;

	logic   valid;
	logic   ready;
	sword_t draw;
	word_t  state_now;
	logic   coin;

	modport source (output valid, draw, state_now, coin, input ready);
	modport sink (input valid, draw, state_now, coin, output ready);
endinterface

>>> rtl/lcg_bounded_random_draw_unit.sv
`timescale 1ns / 1ps
// Bounded random draw unit on a 32-bit linear congruential generator
// (state = state * 0x015A4E35 + 1 mod 2^32). Each request on req carries an
// action and an operand and yields exactly one result on rsp, in order: draw,
// the generator state after the request, and the coin flag. Requests are
// worked one at a time; a new request is taken as soon as the previous one has
// reached the output register, even while that result still waits for rsp.ready.
// Seed load, unused action codes and bounds of zero or less finish without a
// generator step; raw and abs steps go through the bit-serial shift-and-add
// multiplier, which walks the 25 significant bits of the multiplier constant one
// per cycle; bounded draw and coin flip add the restoring divider that retires
// one remainder bit per cycle over the 32 dividend bits. A discard of N steps
// walks the bits of N, with up to 4 multiplications for each bit, and ends
// with one final multiplication; the multiplier stops early once the remaining
// multiplier bits are all zero.
// The generator state resets to zero.
module lcg_bounded_random_draw_unit (
	input logic       clk,
	input logic       arst_n,
	lbrd_req_if.sink   req,
	lbrd_rsp_if.source rsp
);
	import lbrd_pkg::*;

	localparam int unsigned CNT_W = $clog2(WORD_W + 1);
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(WORD_W);

	typedef enum logic [3:0] {
		ST_IDLE,   // wait for a request
		ST_STEP,   // single generator step through the multiplier
		ST_DIV,    // remainder of the bounded draw
		ST_J_TOP,  // discard: examine the next count bit
		ST_J_AM,   // discard: acc_mult * cur_mult
		ST_J_AP,   // discard: acc_plus * cur_mult + cur_plus
		ST_J_CP,   // discard: (cur_mult + 1) * cur_plus
		ST_J_CM,   // discard: cur_mult * cur_mult
		ST_J_FIN,  // discard: acc_mult * state + acc_plus
		ST_EMIT    // hand the result to the output register
	} state_t;

	state_t           state_q;
	action_t          act_q;
	word_t            opnd_q;
	word_t            lcg_q;
	// shift-and-add multiplier
	word_t            mul_a_q;
	word_t            mul_b_q;
	word_t            mul_p_q;
	// affine jump accumulators
	word_t            acc_mult_q;
	word_t            acc_plus_q;
	word_t            cur_mult_q;
	word_t            cur_plus_q;
	word_t            jump_n_q;
	// restoring divider
	word_t            div_d_q;
	word_t            rem_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             neg_q;
	// finished result waiting for the output register
	word_t            res_draw_q;
	logic             res_coin_q;
	// output register
	logic             rsp_valid_q;
	sword_t           rsp_draw_q;
	word_t            rsp_state_q;
	logic             rsp_coin_q;

	logic             mul_state;
	logic             mul_run;
	word_t            mul_next;
	word_t            step_val;
	word_t            step_abs;
	logic             bound_bad;
	logic             small_bound;
	logic [WORD_W:0]  div_trial;
	logic [WORD_W:0]  div_diff;
	logic             div_fit;
	word_t            rem_signed;
	logic             emit_free;

	always_comb begin
		mul_state = (state_q == ST_STEP) || (state_q == ST_J_AM) || (state_q == ST_J_AP) ||
			(state_q == ST_J_CP) || (state_q == ST_J_CM) || (state_q == ST_J_FIN);
		// the multiplier finishes once no multiplier bits remain
		mul_run  = mul_state && (mul_b_q != '0);
		mul_next = mul_p_q + (mul_b_q[0] ? mul_a_q : '0);

		step_val = mul_p_q + LCG_INC;
		// absolute value, the most negative pattern kept as it is
		step_abs = (step_val[WORD_W-1] && (step_val != INT_MIN_PAT)) ? ('0 - step_val) : step_val;

		bound_bad   = (req.operand == '0) || req.operand[WORD_W-1];
		small_bound = (opnd_q <= HIGH_BOUND_LIMIT);

		// one restoring step: bring down the next dividend bit, subtract if it fits
		div_trial  = {rem_q, div_d_q[WORD_W-1]};
		div_diff   = div_trial - {1'b0, opnd_q};
		div_fit    = !div_diff[WORD_W];
		rem_signed = neg_q ? ('0 - rem_q) : rem_q;

		emit_free = !rsp_valid_q || rsp.ready;
	end

	assign req.ready     = (state_q == ST_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.draw      = rsp_draw_q;
	assign rsp.state_now = rsp_state_q;
	assign rsp.coin      = rsp_coin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_q       <= ACT_LOAD;
			opnd_q      <= '0;
			lcg_q       <= '0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			mul_p_q     <= '0;
			acc_mult_q  <= '0;
			acc_plus_q  <= '0;
			cur_mult_q  <= '0;
			cur_plus_q  <= '0;
			jump_n_q    <= '0;
			div_d_q     <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			neg_q       <= 1'b0;
			res_draw_q  <= '0;
			res_coin_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_draw_q  <= '0;
			rsp_state_q <= '0;
			rsp_coin_q  <= 1'b0;
		end else begin
			// drop the result once taken, unless the next one moves in behind it
			if (rsp_valid_q && rsp.ready && (state_q != ST_EMIT)) begin
				rsp_valid_q <= 1'b0;
			end

			// advance the multiplier by one multiplier bit
			if (mul_run) begin
				mul_p_q <= mul_next;
				mul_a_q <= mul_a_q << 1;
				mul_b_q <= mul_b_q >> 1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						act_q      <= req.action;
						opnd_q     <= req.operand;
						res_draw_q <= '0;
						res_coin_q <= 1'b0;
						state_q    <= ST_EMIT;
						unique case (req.action) inside
							ACT_LOAD: begin
								lcg_q <= req.operand;
							end
							ACT_RAW, ACT_ABS: begin
								mul_a_q <= lcg_q;
								mul_b_q <= LCG_MULT;
								mul_p_q <= '0;
								state_q <= ST_STEP;
							end
							ACT_BOUNDED, ACT_COIN: begin
								if (bound_bad) begin
									// no step; a coin flip on such a bound comes up true
									res_coin_q <= (req.action == ACT_COIN);
								end else begin
									mul_a_q <= lcg_q;
									mul_b_q <= LCG_MULT;
									mul_p_q <= '0;
									state_q <= ST_STEP;
								end
							end
							ACT_DISCARD: begin
								acc_mult_q <= LCG_INC;
								acc_plus_q <= '0;
								cur_mult_q <= LCG_MULT;
								cur_plus_q <= LCG_INC;
								jump_n_q   <= req.operand;
								state_q    <= ST_J_TOP;
							end
							default: begin
								// unused codes leave everything as it is
							end
						endcase
					end
				end

				ST_STEP: begin
					if (!mul_run) begin
						lcg_q <= step_val;
						unique case (act_q)
							ACT_RAW: begin
								res_draw_q <= step_val;
								state_q    <= ST_EMIT;
							end
							ACT_ABS: begin
								res_draw_q <= step_abs;
								state_q    <= ST_EMIT;
							end
							default: begin
								// bounded draw: divide the magnitude, negate the remainder only for the most negative pattern
								div_d_q   <= small_bound ? (step_abs >> HIGH_SHIFT) : step_abs;
								neg_q     <= (step_abs == INT_MIN_PAT);
								rem_q     <= '0;
								div_cnt_q <= '0;
								state_q   <= ST_DIV;
							end
						endcase
					end
				end

				ST_DIV: begin
					if (div_cnt_q == DIV_STEPS) begin
						res_draw_q <= rem_signed;
						res_coin_q <= (act_q == ACT_COIN) && (rem_q == '0);
						state_q    <= ST_EMIT;
					end else begin
						rem_q     <= div_fit ? div_diff[WORD_W-1:0] : div_trial[WORD_W-1:0];
						div_d_q   <= div_d_q << 1;
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end

				ST_J_TOP: begin
					mul_p_q <= '0;
					if (jump_n_q == '0) begin
						mul_a_q <= lcg_q;
						mul_b_q <= acc_mult_q;
						state_q <= ST_J_FIN;
					end else if (jump_n_q[0]) begin
						mul_a_q <= cur_mult_q;
						mul_b_q <= acc_mult_q;
						state_q <= ST_J_AM;
					end else begin
						mul_a_q <= cur_plus_q;
						mul_b_q <= cur_mult_q + LCG_INC;
						state_q <= ST_J_CP;
					end
				end

				ST_J_AM: begin
					if (!mul_run) begin
						acc_mult_q <= mul_p_q;
						mul_a_q    <= cur_mult_q;
						mul_b_q    <= acc_plus_q;
						mul_p_q    <= '0;
						state_q    <= ST_J_AP;
					end
				end

				ST_J_AP: begin
					if (!mul_run) begin
						acc_plus_q <= mul_p_q + cur_plus_q;
						mul_a_q    <= cur_plus_q;
						mul_b_q    <= cur_mult_q + LCG_INC;
						mul_p_q    <= '0;
						state_q    <= ST_J_CP;
					end
				end

				ST_J_CP: begin
					if (!mul_run) begin
						cur_plus_q <= mul_p_q;
						mul_a_q    <= cur_mult_q;
						mul_b_q    <= cur_mult_q;
						mul_p_q    <= '0;
						state_q    <= ST_J_CM;
					end
				end

				ST_J_CM: begin
					if (!mul_run) begin
						cur_mult_q <= mul_p_q;
						jump_n_q   <= jump_n_q >> 1;
						state_q    <= ST_J_TOP;
					end
				end

				ST_J_FIN: begin
					if (!mul_run) begin
						lcg_q   <= mul_p_q + acc_plus_q;
						state_q <= ST_EMIT;
					end
				end

				ST_EMIT: begin
					// hold until the output register is free
					if (emit_free) begin
						rsp_valid_q <= 1'b1;
						rsp_draw_q  <= sword_t'(res_draw_q);
						rsp_state_q <= lcg_q;
						rsp_coin_q  <= res_coin_q;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/lbrd_checker.sv
`timescale 1ns / 1ps
`include "lcg_bounded_random_draw_unit_assert.svh"
module lbrd_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input lbrd_pkg::sword_t rsp_draw,
	input lbrd_pkg::word_t  rsp_state_now,
	input logic             rsp_coin
);
	import lbrd_pkg::*;

	// a true coin flip always comes with a zero draw
	`LBRD_ASSERT_IMP(a_coin_zero, rsp_valid && rsp_coin, rsp_draw == '0)
	// only one request is worked at a time
	`LBRD_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)
	// a stalled result holds
	`LBRD_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(rsp_draw) && $stable(rsp_state_now) && $stable(rsp_coin))

endmodule

bind lcg_bounded_random_draw_unit lbrd_checker u_lbrd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_draw     (rsp.draw),
	.rsp_state_now(rsp.state_now),
	.rsp_coin     (rsp.coin)
);
